>>> rtl/rrd_pkg.sv
// Shared types and constants for the reader reply deframer.
// No dependencies; imported by rrd_parser and reader_reply_deframer.
`default_nettype none

package rrd_pkg;

  localparam logic [7:0] MAGIC_FIRST  = 8'hAA;
  localparam logic [7:0] MAGIC_SECOND = 8'hBB;
  localparam logic [4:0] HEADER_SKIP  = 5'd6;

  typedef enum logic [2:0] {
    PH_MAGIC0  = 3'd0,
    PH_MAGIC1  = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_FRAME_END = 2'd1,
    KIND_BAD_MAGIC = 2'd2,
    KIND_BAD_LEN   = 2'd3
  } kind_t;

  // one result transaction from the parser, valid marks that a byte caused one
  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] status;
    logic       checksum_ok;
    logic [3:0] data_count;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/reader_reply_deframer.sv
// Reader reply deframer: parses AA BB framed replies from a serial byte stream.
// Takes one received byte per transaction on the slave side and gives at most
// one result per byte on the master side: a payload data byte (offset six on),
// a frame end with status, checksum match and data count, or a bad magic or
// bad length report, after which it hunts for magic again. A byte is taken
// every cycle unless held off; a result shows the cycle after its byte and
// waits in the output register, which holds off input only while full and unread.
// Depends on rrd_pkg and rrd_parser.
`default_nettype none

module reader_reply_deframer #(
  parameter int MAX_PAYLOAD = 17
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [23:0] m_tdata,   // [7:0] data_byte, [15:8] status,
                                 // [16] checksum_ok, [20:17] data_count, rest 0
  output logic [1:0]  m_tuser    // [1:0] kind
);
  import rrd_pkg::*;

  result_t res;
  logic    accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  rrd_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .rx_byte (s_tdata),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= accept && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      m_tuser <= res.kind;
      m_tdata <= {3'b000, res.data_count, res.checksum_ok, res.status, res.data_byte};
    end
  end

endmodule

`default_nettype wire

>>> rtl/rrd_parser.sv
// Frame parser state machine: consumes one byte per advance and gives the result.
// Depends on rrd_pkg.
`default_nettype none

module rrd_parser #(
  parameter int MAX_PAYLOAD = 17
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             advance,
  input  wire [7:0]       rx_byte,
  output rrd_pkg::result_t res
);
  import rrd_pkg::*;

  phase_t     phase, phase_next;
  logic       first_ok, first_ok_next;
  logic [4:0] frame_length, frame_length_next;
  logic [4:0] byte_pos, byte_pos_next;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] held_status, held_status_next;

  logic       magic_good;
  logic       len_bad;
  logic       last_payload;
  logic       status_hit;
  logic [5:0] pos_inc;
  logic [4:0] cnt_raw;
  logic [3:0] cnt;

  assign magic_good   = first_ok && (rx_byte == MAGIC_SECOND);
  assign len_bad      = rx_byte > 8'(MAX_PAYLOAD);
  assign pos_inc      = {1'b0, byte_pos} + 6'd1;
  assign last_payload = pos_inc >= {1'b0, frame_length};
  assign status_hit   = (frame_length > HEADER_SKIP) ? (byte_pos == HEADER_SKIP - 5'd1)
                                                      : (pos_inc == {1'b0, frame_length});
  assign cnt_raw      = (frame_length > HEADER_SKIP) ? frame_length - HEADER_SKIP : 5'd0;
  assign cnt          = cnt_raw[4] ? 4'hF : cnt_raw[3:0];

  // next state
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_MAGIC0:  phase_next = PH_MAGIC1;
      PH_MAGIC1:  phase_next = magic_good ? PH_LENGTH : PH_MAGIC0;
      PH_LENGTH: begin
        if (len_bad)              phase_next = PH_MAGIC0;
        else if (rx_byte == 8'd0) phase_next = PH_CHECK;
        else                      phase_next = PH_PAYLOAD;
      end
      PH_PAYLOAD: if (last_payload) phase_next = PH_CHECK;
      PH_CHECK:   phase_next = PH_MAGIC0;
      default:    phase_next = PH_MAGIC0;
    endcase
  end

  // datapath registers and result
  always_comb begin
    first_ok_next     = first_ok;
    frame_length_next = frame_length;
    byte_pos_next     = byte_pos;
    running_xor_next  = running_xor;
    held_status_next  = held_status;
    res               = '0;
    case (phase)
      PH_MAGIC0: first_ok_next = (rx_byte == MAGIC_FIRST);
      PH_MAGIC1: begin
        if (!magic_good) begin
          first_ok_next = 1'b0;
          res.valid     = 1'b1;
          res.kind      = KIND_BAD_MAGIC;
        end
      end
      PH_LENGTH: begin
        first_ok_next    = 1'b0;
        byte_pos_next    = '0;
        running_xor_next = '0;
        held_status_next = '0;
        if (len_bad) begin
          frame_length_next = '0;
          res.valid         = 1'b1;
          res.kind          = KIND_BAD_LEN;
        end else begin
          frame_length_next = rx_byte[4:0];
        end
      end
      PH_PAYLOAD: begin
        running_xor_next = running_xor ^ rx_byte;
        if (status_hit) held_status_next = rx_byte;
        byte_pos_next = pos_inc[4:0];
        if (byte_pos >= HEADER_SKIP) begin
          res.valid     = 1'b1;
          res.kind      = KIND_DATA;
          res.data_byte = rx_byte;
        end
      end
      PH_CHECK: begin
        res.valid         = 1'b1;
        res.kind          = KIND_FRAME_END;
        res.status        = held_status;
        res.checksum_ok   = (rx_byte == running_xor);
        res.data_count    = cnt;
        frame_length_next = '0;
        byte_pos_next     = '0;
        running_xor_next  = '0;
        held_status_next  = '0;
      end
      default: begin
        first_ok_next     = 1'b0;
        frame_length_next = '0;
        byte_pos_next     = '0;
        running_xor_next  = '0;
        held_status_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_MAGIC0;
      first_ok     <= 1'b0;
      frame_length <= '0;
      byte_pos     <= '0;
      running_xor  <= '0;
      held_status  <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      first_ok     <= first_ok_next;
      frame_length <= frame_length_next;
      byte_pos     <= byte_pos_next;
      running_xor  <= running_xor_next;
      held_status  <= held_status_next;
    end
  end

  a_len_in_range: assert property (@(posedge clk) disable iff (rst)
    frame_length <= 5'(MAX_PAYLOAD))
    else $error("frame length beyond limit");

  a_pos_below_len: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (byte_pos < frame_length))
    else $error("payload offset past frame length");

  a_magic_pair: assert property (@(posedge clk) disable iff (rst)
    (advance && phase == PH_MAGIC0) |=> (phase == PH_MAGIC1))
    else $error("first magic byte not followed by second magic phase");

endmodule

`default_nettype wire

>>> tb/reader_reply_deframer_tb.sv
// Testbench for reader_reply_deframer: drives framed and damaged reply byte
// streams with random gaps and stalls, predicts every result and checks them.
// Depends on rrd_pkg and the reader_reply_deframer RTL.
`timescale 1ns / 100ps

module reader_reply_deframer_tb;
  import rrd_pkg::*;

  localparam int MAX_LEN = 17;
  localparam int QUIET_FROM = 800;
  localparam int QUIET_TO = 1400;

  typedef struct {
    logic [7:0] b;
    bit         hold;   // wait for every owed reply before sending
  } rx_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] status;
    logic       ok;
    logic [3:0] count;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  wire         s_tready;
  logic [7:0]  s_tdata = 8'h00;
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  wire  [23:0] m_tdata;
  wire  [1:0]  m_tuser;

  rx_item_t rx_pending[$];
  reply_t   replies_due[$];
  bit       hold_next = 1'b0;
  int       cyc = 0;
  int       errors = 0;

  // parser copy kept by the testbench
  phase_t     ph;
  logic       aa_seen;
  logic [4:0] flen;
  logic [4:0] pos;
  logic [7:0] xr;
  logic [7:0] held_st;

  reader_reply_deframer #(.MAX_PAYLOAD(MAX_LEN)) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cyc <= cyc + 1;

  function automatic void rehunt();
    ph = PH_MAGIC0;
    aa_seen = 1'b0;
    flen = '0;
    pos = '0;
    xr = '0;
    held_st = '0;
  endfunction

  function automatic void owe(kind_t k, logic [7:0] d, logic [7:0] s, logic ok,
                              logic [3:0] c);
    replies_due.push_back('{k, d, s, ok, c});
  endfunction

  function automatic void parse_rx_byte(logic [7:0] b);
    int cnt;
    case (ph)
      PH_MAGIC0: begin
        aa_seen = (b == MAGIC_FIRST);
        ph = PH_MAGIC1;
      end
      PH_MAGIC1: begin
        if (aa_seen && b == MAGIC_SECOND) begin
          ph = PH_LENGTH;
        end else begin
          rehunt();
          owe(KIND_BAD_MAGIC, 8'h00, 8'h00, 1'b0, 4'd0);
        end
      end
      PH_LENGTH: begin
        if (int'(b) > MAX_LEN || b >= 8'd128) begin
          rehunt();
          owe(KIND_BAD_LEN, 8'h00, 8'h00, 1'b0, 4'd0);
        end else begin
          flen = b[4:0];
          pos = '0;
          xr = '0;
          held_st = '0;
          ph = (flen == 0) ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        xr = xr ^ b;
        // status: byte five of a long frame, else the last payload byte
        if (flen > HEADER_SKIP ? (int'(pos) == HEADER_SKIP - 1) : (int'(pos) + 1 == flen))
          held_st = b;
        if (int'(pos) + 1 >= flen) ph = PH_CHECK;
        if (pos >= HEADER_SKIP) owe(KIND_DATA, b, 8'h00, 1'b0, 4'd0);
        pos = pos + 5'd1;
      end
      PH_CHECK: begin
        cnt = (flen > HEADER_SKIP) ? int'(flen) - int'(HEADER_SKIP) : 0;
        if (cnt > 15) cnt = 15;
        owe(KIND_FRAME_END, 8'h00, held_st, b == xr, cnt[3:0]);
        rehunt();
      end
      default: rehunt();
    endcase
  endfunction

  function automatic void put(logic [7:0] b);
    rx_pending.push_back('{b, hold_next});
    hold_next = 1'b0;
  endfunction

  function automatic void queue_frame(int len, bit sum_good);
    logic [7:0] x;
    logic [7:0] p;
    put(MAGIC_FIRST);
    put(MAGIC_SECOND);
    put(len[7:0]);
    if (len <= MAX_LEN) begin
      x = 8'h00;
      for (int i = 0; i < len; i++) begin
        p = 8'($urandom_range(255));
        x = x ^ p;
        put(p);
      end
      put(sum_good ? x : x ^ 8'($urandom_range(255, 1)));
    end
  endfunction

  // sender
  always @(posedge clk) begin : drv
    bit gap;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        parse_rx_byte(s_tdata);
        void'(rx_pending.pop_front());
      end
      if (!s_tvalid || s_tready) begin
        gap = !(cyc >= QUIET_FROM && cyc < QUIET_TO) && ($urandom_range(99) < 10);
        if (rx_pending.size() != 0 && !gap &&
            !(rx_pending[0].hold && replies_due.size() != 0)) begin
          s_tvalid <= 1'b1;
          s_tdata <= rx_pending[0].b;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin : mon
    reply_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (replies_due.size() == 0) begin
          $display("%0t: result with nothing owed, kind %0d tdata %h", $time, m_tuser,
                   m_tdata);
          errors++;
        end else begin
          want = replies_due.pop_front();
          if (m_tuser !== want.kind) begin
            $display("%0t: kind expected %0d, actual %0d", $time, want.kind, m_tuser);
            errors++;
          end
          if (m_tdata[7:0] !== want.data_byte) begin
            $display("%0t: data_byte expected %h, actual %h", $time, want.data_byte,
                     m_tdata[7:0]);
            errors++;
          end
          if (m_tdata[15:8] !== want.status) begin
            $display("%0t: status expected %h, actual %h", $time, want.status,
                     m_tdata[15:8]);
            errors++;
          end
          if (m_tdata[16] !== want.ok) begin
            $display("%0t: checksum_ok expected %b, actual %b", $time, want.ok,
                     m_tdata[16]);
            errors++;
          end
          if (m_tdata[20:17] !== want.count) begin
            $display("%0t: data_count expected %0d, actual %0d", $time, want.count,
                     m_tdata[20:17]);
            errors++;
          end
        end
      end
      m_tready <= !(!(cyc >= QUIET_FROM && cyc < QUIET_TO) && ($urandom_range(99) < 10));
    end
  end

  initial begin
    int r;
    int n;
    rehunt();

    // directed: empty frames, both magic faults, both length faults, a long frame
    queue_frame(0, 1'b1);
    queue_frame(0, 1'b0);
    put(8'h00);
    put(MAGIC_SECOND);
    put(MAGIC_FIRST);
    put(8'h00);
    queue_frame(MAX_LEN + 1, 1'b1);
    queue_frame(255, 1'b1);
    put(MAGIC_FIRST);
    put(MAGIC_SECOND);
    put(8'd7);
    put(8'hFF);
    put(8'h00);
    put(8'h55);
    put(8'hAA);
    put(8'h0F);
    put(8'hF0);
    put(8'h81);
    put(8'hFF ^ 8'h55 ^ 8'hAA ^ 8'h0F ^ 8'hF0 ^ 8'h81);

    // random: mostly well-formed frames, some damage and line noise
    hold_next = 1'b1;
    while (rx_pending.size() < 1750) begin
      if (rx_pending.size() > 900 && rx_pending.size() < 920) hold_next = 1'b1;
      r = $urandom_range(99);
      if (r < 72) begin
        queue_frame($urandom_range(MAX_LEN), $urandom_range(99) < 80);
      end else if (r < 82) begin
        queue_frame($urandom_range(255, MAX_LEN + 1), 1'b1);
      end else if (r < 90) begin
        put($urandom_range(1) ? MAGIC_FIRST : 8'($urandom_range(255)));
        put($urandom_range(1) ? MAGIC_SECOND : 8'($urandom_range(255)));
      end else begin
        // truncated frame or noise; the parser resyncs on its own
        n = $urandom_range(6, 1);
        if ($urandom_range(1)) begin
          put(MAGIC_FIRST);
          put(MAGIC_SECOND);
          put(8'($urandom_range(MAX_LEN, 1)));
        end
        for (int i = 0; i < n; i++) put(8'($urandom_range(255)));
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (rx_pending.size() != 0 || s_tvalid) @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
